// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for RTL that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared widths, reset values, register indexes, record kinds, item struct and sine coefficients.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam int CNT_W            = 9;
  localparam int FLD_W            = 17;
  localparam int XW               = 31;
  localparam int TW               = 32;
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int ANGLE_BITS_DEF   = 16;

  localparam logic [15:0]      RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] LONC_RST   = 9'd32;
  localparam logic [CNT_W-1:0] LATC_RST   = 9'd16;

  // Horner coefficients of sin(pi/2 * x), Q30, innermost first
  localparam logic [TW-1:0] SIN_C0 = 32'd172272;
  localparam logic [TW-1:0] SIN_C1 = 32'd5026995;
  localparam logic [TW-1:0] SIN_C2 = 32'd85569306;
  localparam logic [TW-1:0] SIN_C3 = 32'd693598668;
  localparam logic [TW-1:0] SIN_C4 = 32'd1686629713;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_LONC   = 2'd1,
    REG_LATC   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_POS = 2'd0,
    KIND_NRM = 2'd1,
    KIND_TRI = 2'd2,
    KIND_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] lat;
    logic [CNT_W-1:0] lon;
    logic             err;
    logic             has_tri;
    logic             two;
    logic             lrow;
    logic [FLD_W-1:0] tex_u;
    logic [FLD_W-1:0] tex_v;
    logic [FLD_W-1:0] ul;
    logic [FLD_W-1:0] ll;
  } item_t;

endpackage

// File: rtl/core/uv_sphere_tessellator.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator: UV sphere vertex and triangle record generator
// A word passes the divider chain, phase fold, sine lanes and normal and position stages to the emitter.
// Each grid point yields two to four records (an error word yields one); the record output register,
// one record a cycle while rec_stall does not hold it, sets how fast grid points are taken.
// Reset: synchronous; registers to defaults, pipeline and record outputs empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uv_sphere_tessellator #(
  parameter int MAX_SEGMENTS = uvst_pkg::MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = uvst_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [uvst_pkg::CNT_W-1:0]        lat_index,
  input  logic [uvst_pkg::CNT_W-1:0]        lon_index,
  output logic                              rec_valid,
  input  logic                              rec_stall,
  output logic [1:0]                        kind,
  output logic                              last,
  output logic signed [uvst_pkg::FLD_W-1:0] coord_x,
  output logic signed [uvst_pkg::FLD_W-1:0] coord_y,
  output logic signed [uvst_pkg::FLD_W-1:0] coord_z,
  output logic [uvst_pkg::FLD_W-1:0]        tex_u,
  output logic [uvst_pkg::FLD_W-1:0]        tex_v,
  output logic [uvst_pkg::FLD_W-1:0]        corner_a,
  output logic [uvst_pkg::FLD_W-1:0]        corner_b,
  output logic [uvst_pkg::FLD_W-1:0]        corner_c
);

  localparam int F  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int QW = F + 1;
  localparam int XS = F + 1;
  localparam int PS = F + 10;
  localparam int NS = F + 11;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam int CW = uvst_pkg::CNT_W;
  localparam int FW = uvst_pkg::FLD_W;
  localparam int XW = uvst_pkg::XW;
  localparam int TW = uvst_pkg::TW;

  // Magnitude product rounded half away from zero, >>15
  function automatic logic signed [FW-1:0] mr15(input logic signed [FW-1:0] a,
                                                input logic signed [FW:0]   b);
    logic [FW-1:0] ma;
    logic [FW:0]   mb;
    logic [35:0]   p;
    logic [FW-1:0] m;
    ma = a[FW-1] ? FW'(-a) : FW'(a);
    mb = b[FW] ? (FW+1)'(-b) : (FW+1)'(b);
    p  = 36'(ma) * 36'(mb) + 36'd16384;
    m  = p[31:15];
    return (a[FW-1] ^ b[FW]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [CW-1:0] sat_cnt(input logic [CW-1:0] v,
                                            input logic [CW-1:0] lo);
    logic [CW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (int'(v) > MAX_SEGMENTS) r = CW'(MAX_SEGMENTS);
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [15:0]   radius;
  logic [CW-1:0] lonc_r;
  logic [CW-1:0] latc_r;
  logic [CW-1:0] lonc;
  logic [CW-1:0] latc;
  logic          wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign lonc   = sat_cnt(lonc_r, 9'd3);
  assign latc   = sat_cnt(latc_r, 9'd2);

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= uvst_pkg::RADIUS_RST;
      lonc_r <= uvst_pkg::LONC_RST;
      latc_r <= uvst_pkg::LATC_RST;
    end else if (wr) begin
      case (paddr[3:2])
        uvst_pkg::REG_RADIUS: radius <= pwdata[15:0];
        uvst_pkg::REG_LONC:   lonc_r <= pwdata[CW-1:0];
        uvst_pkg::REG_LATC:   latc_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uvst_pkg::REG_RADIUS: prdata = {16'd0, radius};
      uvst_pkg::REG_LONC:   prdata = {23'd0, lonc_r};
      uvst_pkg::REG_LATC:   prdata = {23'd0, latc_r};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                  adv;
  logic                  em_take;
  logic                  vld [NS];
  uvst_pkg::item_t       itm [NS];
  uvst_pkg::item_t       itm0;
  uvst_pkg::item_t       itm_x;

  assign item_stall = !adv;

  // Classify the incoming word against the segment counts
  always_comb begin
    itm0         = '0;
    itm0.lat     = lat_index;
    itm0.lon     = lon_index;
    itm0.err     = (lat_index > latc) || (lon_index > lonc);
    itm0.has_tri = (lat_index < latc) && (lon_index < lonc);
    itm0.lrow    = lat_index == (latc - 9'd1);
    itm0.two     = (lat_index != 9'd0) && (lat_index != (latc - 9'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= item_valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[0] <= itm0;
      for (int k = 1; k < NS; k++) itm[k] <= (k == XS) ? itm_x : itm[k-1];
    end
  end

  // ---------------- division chain ----------------
  // lane 0: lat * 2^F / latc, lane 1: lon * 2^F / lonc
  logic [CW-1:0] rem_s [0:F][2];
  logic [QW-1:0] q_s   [0:F][2];
  logic [CW-1:0] dv    [2];
  logic [CW-1:0] nv    [2];

  assign dv[0] = latc;
  assign dv[1] = lonc;
  assign nv[0] = lat_index;
  assign nv[1] = lon_index;

  // Take the top quotient bit before the chain
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        rem_s[0][l] <= (nv[l] >= dv[l]) ? (nv[l] - dv[l]) : nv[l];
        q_s[0][l]   <= QW'(nv[l] >= dv[l]);
      end
    end
  end

  for (genvar j = 1; j <= F; j++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      uvst_div_cell #(.QW(QW)) u_cell (
        .clk     (clk),
        .en      (adv),
        .d       (dv[l]),
        .rem_in  (rem_s[j-1][l]),
        .q_in    (q_s[j-1][l]),
        .rem_out (rem_s[j][l]),
        .q_out   (q_s[j][l])
      );
    end
  end

  // ---------------- phases, texture, indices ----------------
  logic [ANGLE_BITS-1:0] lat_ph;
  logic [ANGLE_BITS-1:0] lon_ph;
  logic [ANGLE_BITS-1:0] ph [4];
  logic [19:0]           row_w;
  logic [19:0]           ul_w;
  logic [19:0]           ll_w;

  assign lat_ph = ANGLE_BITS'(q_s[F][0] >> (F - ANGLE_BITS + 1));
  assign lon_ph = ANGLE_BITS'(q_s[F][1] >> (F - ANGLE_BITS));
  assign ph[0]  = lat_ph;
  assign ph[1]  = lat_ph + QTR;
  assign ph[2]  = lon_ph;
  assign ph[3]  = lon_ph + QTR;
  assign row_w  = 20'(lonc) + 20'd1;
  assign ul_w   = 20'(itm[XS-1].lat) * row_w + 20'(itm[XS-1].lon);
  assign ll_w   = ul_w + row_w;

  always_comb begin
    itm_x       = itm[XS-1];
    itm_x.tex_v = FW'(q_s[F][0] >> (F - 16));
    itm_x.tex_u = FW'(q_s[F][1] >> (F - 16));
    itm_x.ul    = ul_w[FW-1:0];
    itm_x.ll    = ll_w[FW-1:0];
  end

  // Fold each phase onto the quarter wave
  logic [XW-1:0]         xs_x [4];
  logic [1:0]            xs_q [4];
  logic [ANGLE_BITS-2:0] rr   [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rr[l] = {1'b0, ph[l][ANGLE_BITS-3:0]};
      if (ph[l][ANGLE_BITS-2]) rr[l] = (ANGLE_BITS-1)'(QTR) - rr[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        xs_x[l] <= XW'(rr[l]) << (32 - ANGLE_BITS);
        xs_q[l] <= ph[l][ANGLE_BITS-1:ANGLE_BITS-2];
      end
    end
  end

  // ---------------- sine lanes ----------------
  logic [XW-1:0] h_x  [0:4][4];
  logic [XW-1:0] h_x2 [0:4][4];
  logic [TW-1:0] h_t  [0:4][4];
  logic [1:0]    h_q  [0:4][4];
  logic [61:0]   sq   [4];

  // Square the folded angle and seed the polynomial
  always_comb begin
    for (int l = 0; l < 4; l++) sq[l] = 62'(xs_x[l]) * 62'(xs_x[l]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        h_x[0][l]  <= xs_x[l];
        h_x2[0][l] <= sq[l][60:30];
        h_t[0][l]  <= uvst_pkg::SIN_C0;
        h_q[0][l]  <= xs_q[l];
      end
    end
  end

  for (genvar k = 1; k <= 4; k++) begin : g_horner
    for (genvar l = 0; l < 4; l++) begin : g_lane
      uvst_sin_cell #(
        .COEF((k == 1) ? uvst_pkg::SIN_C1 : (k == 2) ? uvst_pkg::SIN_C2 :
              (k == 3) ? uvst_pkg::SIN_C3 : uvst_pkg::SIN_C4)
      ) u_cell (
        .clk      (clk),
        .en       (adv),
        .x_in     (h_x[k-1][l]),
        .x2_in    (h_x2[k-1][l]),
        .t_in     (h_t[k-1][l]),
        .quad_in  (h_q[k-1][l]),
        .x_out    (h_x[k][l]),
        .x2_out   (h_x2[k][l]),
        .t_out    (h_t[k][l]),
        .quad_out (h_q[k][l])
      );
    end
  end

  // Final multiply by x
  logic [62:0]           sp    [4];
  logic [TW-1:0]         s_raw [4];
  logic [1:0]            s_q   [4];
  logic [32:0]           s_rnd [4];
  logic [17:0]           s_mag [4];
  logic signed [FW-1:0]  q15   [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sp[l]    = 63'(h_x[4][l]) * 63'(h_t[4][l]);
      s_rnd[l] = 33'(s_raw[l]) + 33'd16384;
      s_mag[l] = s_rnd[l][32:15];
      if (s_mag[l] > 18'd32768) s_mag[l] = 18'd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s_raw[l] <= sp[l][61:30];
        s_q[l]   <= h_q[4][l];
        // round to Q1.15, cap at one, apply quadrant sign
        q15[l]   <= s_q[l][1] ? -$signed(FW'(s_mag[l])) : $signed(FW'(s_mag[l]));
      end
    end
  end

  // ---------------- normal and position ----------------
  logic signed [FW-1:0] nx, ny, nz;
  logic signed [FW-1:0] pn [3];
  logic signed [FW-1:0] pp [3];
  logic signed [FW:0]   rad;

  assign rad = $signed({2'b00, radius[15:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      nx    <= mr15(q15[0], (FW+1)'(q15[3]));
      ny    <= mr15(q15[0], (FW+1)'(q15[2]));
      nz    <= q15[1];
      pn[0] <= nx;
      pn[1] <= ny;
      pn[2] <= nz;
      pp[0] <= mr15(nx, rad);
      pp[1] <= mr15(ny, rad);
      pp[2] <= mr15(nz, rad);
    end
  end

  // ---------------- record emitter ----------------
  logic                 em_vld;
  uvst_pkg::item_t      em_itm;
  logic signed [FW-1:0] em_p [3];
  logic signed [FW-1:0] em_n [3];
  logic [1:0]           em_idx;
  logic [1:0]           em_cnt;
  logic                 out_load;
  logic                 em_end;

  assign out_load = em_vld && (!rec_valid || !rec_stall);
  assign em_end   = em_idx == em_cnt;
  assign em_take  = !em_vld || (out_load && em_end);
  assign adv      = !vld[PS] || em_take;

  // Take a finished word or step to its next record
  always_ff @(posedge clk) begin
    if (rst) begin
      em_vld <= 1'b0;
      em_idx <= 2'd0;
    end else if (em_take) begin
      em_vld <= vld[PS];
      em_idx <= 2'd0;
    end else if (out_load) begin
      em_idx <= em_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (em_take) begin
      em_itm <= itm[PS];
      em_p   <= pp;
      em_n   <= pn;
      em_cnt <= itm[PS].has_tri ? (itm[PS].two ? 2'd3 : 2'd2) :
                (itm[PS].err ? 2'd0 : 2'd1);
    end
  end

  // Build the current record
  uvst_pkg::kind_t      nk;
  logic signed [FW-1:0] nc [3];
  logic [FW-1:0]        ntu, ntv, na, nb, nc2;

  always_comb begin
    nk  = uvst_pkg::KIND_POS;
    nc  = '{default: '0};
    ntu = '0;
    ntv = '0;
    na  = '0;
    nb  = '0;
    nc2 = '0;
    case (em_idx)
      2'd0: begin
        if (em_itm.err) begin
          nk = uvst_pkg::KIND_ERR;
        end else begin
          nc  = em_p;
          ntu = em_itm.tex_u;
          ntv = em_itm.tex_v;
        end
      end
      2'd1: begin
        nk = uvst_pkg::KIND_NRM;
        nc = em_n;
      end
      2'd2: begin
        nk  = uvst_pkg::KIND_TRI;
        na  = em_itm.ul;
        nb  = em_itm.lrow ? (em_itm.ul + 17'd1) : (em_itm.ll + 17'd1);
        nc2 = em_itm.ll;
      end
      default: begin
        nk  = uvst_pkg::KIND_TRI;
        na  = em_itm.ul;
        nb  = em_itm.ul + 17'd1;
        nc2 = em_itm.ll + 17'd1;
      end
    endcase
  end

  // ---------------- output register ----------------
  uvst_pkg::kind_t rec_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (out_load) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rec_kind <= nk;
      last     <= em_end;
      coord_x  <= nc[0];
      coord_y  <= nc[1];
      coord_z  <= nc[2];
      tex_u    <= ntu;
      tex_v    <= ntv;
      corner_a <= na;
      corner_b <= nb;
      corner_c <= nc2;
    end
  end

  assign kind = rec_kind;

  // ---------------- assertions ----------------
  `ASSERT_IMPLIES(a_err_last, clk, rst, rec_valid && rec_kind == uvst_pkg::KIND_ERR, last, "error record not last")
  `ASSERT_IMPLIES(a_pos_not_last, clk, rst, rec_valid && rec_kind == uvst_pkg::KIND_POS, !last, "position record marked last")
  `ASSERT_IMPLIES(a_idx_range, clk, rst, em_vld, em_idx <= em_cnt, "record index beyond count")
  `ASSERT_NEXT(a_hold_done, clk, rst, vld[PS] && !em_take, vld[PS], "finished word lost while emitter busy")

endmodule

// File: rtl/core/uvst_div_cell.sv
// ----------------------------------------------------------------------------
// uvst_div_cell
// One restoring division step: doubles the remainder and yields a quotient bit.
// ----------------------------------------------------------------------------
module uvst_div_cell #(
  parameter int QW = 17
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [uvst_pkg::CNT_W-1:0] d,
  input  logic [uvst_pkg::CNT_W-1:0] rem_in,
  input  logic [QW-1:0]              q_in,
  output logic [uvst_pkg::CNT_W-1:0] rem_out,
  output logic [QW-1:0]              q_out
);

  logic [uvst_pkg::CNT_W:0] r2;
  logic [uvst_pkg::CNT_W:0] diff;
  logic                     ge;

  // Trial subtract of the divisor from the doubled remainder
  assign r2   = {rem_in, 1'b0};
  assign ge   = r2 >= {1'b0, d};
  assign diff = r2 - {1'b0, d};

  // Advance remainder and shift in the new quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[uvst_pkg::CNT_W-1:0] : r2[uvst_pkg::CNT_W-1:0];
      q_out   <= {q_in[QW-2:0], ge};
    end
  end

endmodule

// File: rtl/core/uvst_sin_cell.sv
// ----------------------------------------------------------------------------
// uvst_sin_cell
// One Horner step of a sine lane: t = COEF - (x2 * t) >> 30, x, x2 and quadrant passed on.
// ----------------------------------------------------------------------------
module uvst_sin_cell #(
  parameter logic [uvst_pkg::TW-1:0] COEF = uvst_pkg::SIN_C1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [uvst_pkg::XW-1:0] x_in,
  input  logic [uvst_pkg::XW-1:0] x2_in,
  input  logic [uvst_pkg::TW-1:0] t_in,
  input  logic [1:0]              quad_in,
  output logic [uvst_pkg::XW-1:0] x_out,
  output logic [uvst_pkg::XW-1:0] x2_out,
  output logic [uvst_pkg::TW-1:0] t_out,
  output logic [1:0]              quad_out
);

  logic [62:0] prod;

  assign prod = 63'(x2_in) * 63'(t_in);

  // Advance the lane by one coefficient
  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_in;
      x2_out   <= x2_in;
      t_out    <= COEF - prod[61:30];
      quad_out <= quad_in;
    end
  end

endmodule
